/* hdl/fsmf_pkg.sv */
// Shared types and constants for the first substring match finder.
// No dependencies; compile this file first.
package fsmf_pkg;

  localparam int PATTERN_BITS    = 64;
  localparam int PATTERN_SLOTS   = 8;
  localparam int PIDX_BITS       = 3;
  localparam int LEN_BITS        = 4;
  localparam int OUT_OFFSET_BITS = 24;
  localparam int CNT_EXT_BITS    = 32;
  localparam int CFG_INDEX_BITS  = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_BYTES  = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = CFG_INDEX_BITS'(1);

  localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(4);

  // Per-cycle control for every cell of the window chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // One result item.
  typedef struct packed {
    logic                       found;
    logic [OUT_OFFSET_BITS-1:0] match_offset;
  } result_t;

endpackage

/* hdl/fsmf_in_if.sv */
// Input channel: one buffer byte per item plus the end-of-buffer mark.
// No dependencies.
interface fsmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* hdl/fsmf_out_if.sv */
// Result channel: found flag and match start offset.
// No dependencies.
interface fsmf_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [23:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

/* hdl/fsmf_cfg_if.sv */
// Configuration write channel: register index and write data.
// No dependencies.
interface fsmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/fsmf_cell.sv */
// One window cell: holds one byte, passes it to the next cell on a shift
// and compares its incoming byte with its pattern byte. Uses fsmf_pkg.
module fsmf_cell import fsmf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic [7:0] byte_in,
  input  logic [7:0] exp_byte,
  input  logic      active,
  output logic [7:0] byte_out,
  output logic      hit
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      byte_r <= 8'd0;
    end else if (ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;
  // The byte entering this cell is its window content after the shift.
  assign hit      = !active || (byte_in == exp_byte);

endmodule

/* hdl/fsmf_result_reg.sv */
// Output register of the result channel; frees itself as it is drained.
// Uses fsmf_pkg and fsmf_out_if.
module fsmf_result_reg import fsmf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    free,
  fsmf_out_if.source out_chan
);

  logic    valid_r;
  result_t res_r;

  assign free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_chan.valid        = valid_r;
  assign out_chan.found        = res_r.found;
  assign out_chan.match_offset = res_r.match_offset;

endmodule

/* hdl/first_substring_match_finder_top.sv */
// Top level of the first substring match finder.
// Uses fsmf_pkg, the three channel interfaces, fsmf_cell and fsmf_result_reg.
//
// Usage:
//   in_chan carries one buffer byte per item; last_byte marks the final byte.
//   out_chan carries at most one result item per buffer: found=1 with the
//   start offset of the first match, or found=0 and offset 0 on the end byte
//   when no match occurred. Bytes after a match are dropped until the end
//   byte, which clears the window, byte count and found flag.
//   cfg_chan writes the 64-bit pattern (index 0) or the pattern length
//   (index 1, 0 acts as 1, values above MAX_PATTERN_BYTES are clamped).
//   It is always ready and is meant to be used while the block is idle.
// Timing:
//   One item per cycle while the output register is free. The window is a chain
//   of MAX_PATTERN_BYTES cells that compare in parallel, so a result is
//   registered on the accept edge and is visible on out_chan in the next cycle.
//   in_chan is ready whenever the output register is empty or being drained,
//   so a stalled receiver holds in_chan off only while a result waits.
// Reset:
//   Synchronous, active low. Clears the window, count, found flag and output
//   valid; pattern resets to zero and length to 4.
module first_substring_match_finder_top import fsmf_pkg::*; #(
  parameter int MAX_PATTERN_BYTES = 8,
  parameter int OFFSET_BITS       = 24
) (
  input logic        clk,
  input logic        rst_n,
  fsmf_in_if.sink    in_chan,
  fsmf_out_if.source out_chan,
  fsmf_cfg_if.sink   cfg_chan
);

  // Configuration registers.
  logic [PATTERN_BITS-1:0] pattern_r;
  logic [LEN_BITS-1:0]     length_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= LEN_RESET;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        REG_PATTERN_BYTES:  pattern_r <= cfg_chan.data;
        REG_PATTERN_LENGTH: length_r  <= cfg_chan.data[LEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, clamped to 1..MAX_PATTERN_BYTES.
  logic [LEN_BITS-1:0] eff_len;

  always_comb begin
    if (length_r == '0) begin
      eff_len = LEN_BITS'(1);
    end else if (length_r > LEN_BITS'(MAX_PATTERN_BYTES)) begin
      eff_len = LEN_BITS'(MAX_PATTERN_BYTES);
    end else begin
      eff_len = length_r;
    end
  end

  // Buffer state.
  logic [OFFSET_BITS-1:0] bytes_seen_r, bytes_seen_nxt;
  logic                   match_done_r, match_done_nxt;

  logic      res_free;
  logic      in_acc;
  cell_ctl_t ctl;

  assign in_chan.ready = res_free;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // After a match the window freezes; the end byte always clears it.
  assign ctl.shift = in_acc && !match_done_r;
  assign ctl.clear = in_acc && in_chan.last_byte;

  // Window chain. Cell k is the k-th newest byte and pairs with pattern
  // byte eff_len-1-k while it lies inside the pattern length.
  logic [7:0]                   chain [MAX_PATTERN_BYTES+1];
  logic [MAX_PATTERN_BYTES-1:0] hits;

  assign chain[0] = in_chan.data_byte;

  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    logic [LEN_BITS-1:0] pidx;
    logic [7:0]          exp_byte;
    logic                active;

    assign active   = LEN_BITS'(k) < eff_len;
    assign pidx     = eff_len - LEN_BITS'(1) - LEN_BITS'(k);
    assign exp_byte = pattern_r[pidx[PIDX_BITS-1:0]*8 +: 8];

    fsmf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .byte_in  (chain[k]),
      .exp_byte (exp_byte),
      .active   (active),
      .byte_out (chain[k+1]),
      .hit      (hits[k])
    );
  end

  // Saturating byte count including the byte being accepted.
  logic [OFFSET_BITS-1:0]  seen_inc;
  logic [OFFSET_BITS-1:0]  len_wide;
  logic [OFFSET_BITS-1:0]  start_off;
  logic [CNT_EXT_BITS-1:0] start_ext;
  logic                    match;
  logic                    emit;
  result_t                 res;

  assign seen_inc  = (bytes_seen_r == '1) ? bytes_seen_r : bytes_seen_r + OFFSET_BITS'(1);
  assign len_wide  = OFFSET_BITS'(eff_len);
  assign start_off = seen_inc - len_wide;
  assign start_ext = CNT_EXT_BITS'(start_off);

  assign match = ctl.shift && (seen_inc >= len_wide) && (&hits);
  assign emit  = match || (ctl.shift && in_chan.last_byte);

  assign res.found        = match;
  assign res.match_offset = match ? start_ext[OUT_OFFSET_BITS-1:0] : '0;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    match_done_nxt = match_done_r;
    if (ctl.clear) begin
      bytes_seen_nxt = '0;
      match_done_nxt = 1'b0;
    end else if (ctl.shift) begin
      bytes_seen_nxt = seen_inc;
      match_done_nxt = match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= '0;
      match_done_r <= 1'b0;
    end else begin
      bytes_seen_r <= bytes_seen_nxt;
      match_done_r <= match_done_nxt;
    end
  end

  fsmf_result_reg u_result (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (emit),
    .res      (res),
    .free     (res_free),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  // The end byte of a buffer that had no earlier match always yields a result.
  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.last_byte && !match_done_r) |=> out_chan.valid)
    else $error("end byte without earlier match gave no result");

  // The end byte leaves the buffer state cleared.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.last_byte) |=> (bytes_seen_r == '0 && !match_done_r))
    else $error("buffer state not cleared after end byte");

  // The found flag is only ever set together with a reported match.
  a_done_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(match_done_r) |-> (out_chan.valid && out_chan.found))
    else $error("found flag set without a found result");

  // While a match is pending, no further result may be produced.
  a_no_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    match_done_r |-> !match)
    else $error("second match reported within one buffer");
`endif

endmodule
